/* hdl/cmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message parser package
// Shared types and constants for the byte classifier, the option parser and
// the record queue.
// ----------------------------------------------------------------------------
package cmp_pkg;

  // Default limit on accepted options per message.
  localparam int unsigned MAX_OPTIONS_DEF = 16;
  // Longest token that the header may announce.
  localparam logic [3:0] MAX_TOKEN = 4'd8;

  // Depth of the classified byte queue and of the record queue.
  localparam int unsigned FQ_DEPTH = 2;
  localparam int unsigned RQ_DEPTH = 4;

  // Option header nibbles with a special meaning.
  localparam logic [3:0] NIB_EXT1 = 4'd13;
  localparam logic [3:0] NIB_EXT2 = 4'd14;
  localparam logic [3:0] NIB_STOP = 4'd15;
  localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;

  // Offsets added to one-byte and two-byte extensions.
  localparam logic [15:0] EXT1_BIAS = 16'd13;
  localparam logic [15:0] EXT2_BIAS = 16'd269;

  // Record kinds.
  localparam logic REC_OPTION = 1'b0;
  localparam logic REC_END    = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT_HDR  = 3'd1,
    ST_TOKEN_LONG = 3'd2,
    ST_TOKEN_CUT  = 3'd3,
    ST_OPT_ERR    = 3'd4
  } status_e;

  // Class of the delta nibble of a byte, worked out when the byte enters.
  typedef enum logic [1:0] {
    DK_PLAIN,
    DK_EXT1,
    DK_EXT2,
    DK_STOP
  } dkind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       marker;
    dkind_e     dkind;
  } byte_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] option_number;
    logic [15:0] opt_len;
    logic [15:0] data_offset;
    logic [2:0]  status;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [4:0]  option_count;
    logic [15:0] payload_length;
  } rec_t;

  // Up to two records written into the record queue in one cycle.
  typedef struct packed {
    logic en0;
    logic en1;
    rec_t rec0;
    rec_t rec1;
  } rq_wr_t;

endpackage

/* hdl/cmp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP byte classifier
// Accepts packet bytes, tags each with its option nibble class and holds
// them in a short queue for the option parser.
// ----------------------------------------------------------------------------
module cmp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          valid_o,
  input  logic          take_i,
  output cmp_pkg::byte_t byte_o
);
  import cmp_pkg::*;

  localparam int unsigned AW = $clog2(FQ_DEPTH);

  byte_t          mem_q [FQ_DEPTH];
  logic  [AW:0]   wr_q, wr_d, rd_q, rd_d;
  byte_t          cls;
  logic           wr_en;

  always_comb begin
    cls.data   = data_byte_i;
    cls.last   = last_byte_i;
    cls.marker = (data_byte_i == PAYLOAD_MARKER);
    case (data_byte_i[7:4])
      NIB_EXT1: cls.dkind = DK_EXT1;
      NIB_EXT2: cls.dkind = DK_EXT2;
      NIB_STOP: cls.dkind = DK_STOP;
      default:  cls.dkind = DK_PLAIN;
    endcase
  end

  assign full    = (wr_q[AW] != rd_q[AW]) && (wr_q[AW-1:0] == rd_q[AW-1:0]);
  assign valid_o = (wr_q != rd_q);
  assign byte_o  = mem_q[rd_q[AW-1:0]];
  assign wr_en   = push && !full;

  assign wr_d = wr_en ? wr_q + (AW+1)'(1) : wr_q;
  assign rd_d = (take_i && valid_o) ? rd_q + (AW+1)'(1) : rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q[AW-1:0]] <= cls;
    end
  end

endmodule

/* hdl/cmp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP option parser
// Walks header, token and options one classified byte per cycle while the
// record queue has room, and writes option and end records into it.
// ----------------------------------------------------------------------------
module cmp_back #(
  parameter int unsigned MAX_OPTIONS = cmp_pkg::MAX_OPTIONS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            take_o,
  input  cmp_pkg::byte_t  byte_i,
  input  logic            room_i,
  output cmp_pkg::rq_wr_t wr_o
);
  import cmp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_OPTIONS + 1);
  localparam logic [CntW-1:0] MaxOpt = CntW'(MAX_OPTIONS);

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3,
    PH_TOKEN, PH_OPT,
    PH_DX1, PH_DXH, PH_DXL,
    PH_LX1, PH_LXH, PH_LXL,
    PH_VALUE, PH_MARK, PH_PAYLOAD, PH_IGNORE
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [15:0]     cnt_q, cnt_d;
  logic [15:0]     running_q, running_d;
  logic [15:0]     delta_q, delta_d;
  logic [15:0]     len_q, len_d;
  logic [3:0]      lnib_q, lnib_d;
  logic [15:0]     remain_q, remain_d;
  logic [15:0]     vstart_q, vstart_d;
  logic [31:0]     hdr_q, hdr_d;
  logic [CntW-1:0] seen_q, seen_d;
  status_e         err_q, err_d;
  logic [15:0]     pstart_q, pstart_d;

  logic            do_len, do_fin, do_cmp;
  logic            opt_emit;
  logic [7:0]      b;
  status_e         st;
  logic [15:0]     poff, plen;
  logic [4:0]      end_cnt;
  rec_t            opt_rec, end_rec;

  function automatic logic [15:0] sat_next(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic rec_t make_rec(
    input logic        kind,
    input logic [15:0] num,
    input logic [15:0] len,
    input logic [15:0] off,
    input status_e     stat,
    input logic [4:0]  cnt,
    input logic [15:0] pl,
    input logic [31:0] hw
  );
    rec_t r;
    r.kind           = kind;
    r.option_number  = num;
    r.opt_len        = len;
    r.data_offset    = off;
    r.status         = stat;
    r.version        = hw[31:30];
    r.msg_type       = hw[29:28];
    r.token_length   = hw[27:24];
    r.code           = hw[23:16];
    r.message_id     = hw[15:0];
    r.option_count   = cnt;
    r.payload_length = pl;
    return r;
  endfunction

  assign take_o = valid_i && room_i;
  assign b      = byte_i.data;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    running_d = running_q;
    delta_d   = delta_q;
    len_d     = len_q;
    lnib_d    = lnib_q;
    remain_d  = remain_q;
    vstart_d  = vstart_q;
    hdr_d     = hdr_q;
    seen_d    = seen_q;
    err_d     = err_q;
    pstart_d  = pstart_q;
    do_len    = 1'b0;
    do_fin    = 1'b0;
    do_cmp    = 1'b0;
    opt_emit  = 1'b0;
    st        = ST_OK;
    poff      = '0;
    plen      = '0;
    end_cnt   = '0;

    if (take_o) begin
      case (phase_q)
        PH_HDR0: begin
          hdr_d[31:24] = b;
          phase_d      = PH_HDR1;
        end
        PH_HDR1: begin
          hdr_d[23:16] = b;
          phase_d      = PH_HDR2;
        end
        PH_HDR2: begin
          hdr_d[15:8] = b;
          phase_d     = PH_HDR3;
        end
        PH_HDR3: begin
          hdr_d[7:0] = b;
          if (hdr_q[27:24] > MAX_TOKEN) begin
            err_d   = ST_TOKEN_LONG;
            phase_d = PH_IGNORE;
          end else if (hdr_q[27:24] == 4'd0) begin
            phase_d = PH_OPT;
          end else begin
            remain_d = 16'(hdr_q[27:24]);
            phase_d  = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          remain_d = remain_q - 16'd1;
          if (remain_d == 16'd0) begin
            phase_d = PH_OPT;
          end
        end
        PH_OPT: begin
          if (byte_i.marker) begin
            pstart_d = sat_next(cnt_q);
            phase_d  = PH_MARK;
          end else begin
            lnib_d = b[3:0];
            case (byte_i.dkind)
              DK_STOP: phase_d = PH_IGNORE;
              DK_EXT1: phase_d = PH_DX1;
              DK_EXT2: phase_d = PH_DXH;
              default: begin
                delta_d = {12'd0, b[7:4]};
                do_len  = 1'b1;
              end
            endcase
          end
        end
        PH_DX1: begin
          delta_d = {8'd0, b} + EXT1_BIAS;
          do_len  = 1'b1;
        end
        PH_DXH: begin
          delta_d = {b, 8'd0};
          phase_d = PH_DXL;
        end
        PH_DXL: begin
          delta_d = {delta_q[15:8], b} + EXT2_BIAS;
          do_len  = 1'b1;
        end
        PH_LX1: begin
          len_d  = {8'd0, b} + EXT1_BIAS;
          do_fin = 1'b1;
        end
        PH_LXH: begin
          len_d   = {b, 8'd0};
          phase_d = PH_LXL;
        end
        PH_LXL: begin
          len_d  = {len_q[15:8], b} + EXT2_BIAS;
          do_fin = 1'b1;
        end
        PH_VALUE: begin
          remain_d = remain_q - 16'd1;
          if (remain_d == 16'd0) begin
            do_cmp = 1'b1;
          end
        end
        PH_MARK: begin
          phase_d = PH_PAYLOAD;
        end
        default: begin
        end
      endcase

      // Length nibble of the option header, once the delta is known.
      if (do_len) begin
        if (lnib_d == NIB_EXT1) begin
          phase_d = PH_LX1;
        end else if (lnib_d == NIB_EXT2) begin
          phase_d = PH_LXH;
        end else begin
          len_d  = {12'd0, lnib_d};
          do_fin = 1'b1;
        end
      end

      // Option header complete: the value starts with the next byte.
      if (do_fin) begin
        remain_d = len_d;
        vstart_d = sat_next(cnt_q);
        if (len_d == 16'd0) begin
          do_cmp = 1'b1;
        end else begin
          phase_d = PH_VALUE;
        end
      end

      if (do_cmp) begin
        if (seen_q >= MaxOpt) begin
          err_d   = ST_OPT_ERR;
          phase_d = PH_IGNORE;
        end else begin
          running_d = running_q + delta_d;
          seen_d    = seen_q + CntW'(1);
          opt_emit  = 1'b1;
          phase_d   = PH_OPT;
        end
      end

      cnt_d = sat_next(cnt_q);

      if (byte_i.last) begin
        if (phase_q == PH_HDR0 || phase_q == PH_HDR1 || phase_q == PH_HDR2) begin
          st = ST_SHORT_HDR;
        end else if (phase_d == PH_IGNORE) begin
          st = err_d;
        end else if (phase_d == PH_TOKEN) begin
          st = ST_TOKEN_CUT;
        end else if (phase_d == PH_DX1 || phase_d == PH_DXH || phase_d == PH_DXL ||
                     phase_d == PH_LX1 || phase_d == PH_LXH || phase_d == PH_LXL ||
                     phase_d == PH_VALUE) begin
          st = ST_OPT_ERR;
        end else if (phase_d == PH_PAYLOAD) begin
          poff = pstart_d;
          plen = cnt_d - pstart_d;
        end
        if (st == ST_OK || st == ST_OPT_ERR) begin
          end_cnt = 5'(seen_d);
        end
      end
    end

    opt_rec = make_rec(REC_OPTION, running_d, len_d, vstart_d, ST_OK,
                       5'(seen_d), 16'd0, hdr_d);
    end_rec = make_rec(REC_END, running_d, 16'd0, poff, st, end_cnt, plen, hdr_d);

    // An option record always goes ahead of the end record of the same byte.
    wr_o.en0  = take_o && (opt_emit || byte_i.last);
    wr_o.en1  = take_o && opt_emit && byte_i.last;
    wr_o.rec0 = opt_emit ? opt_rec : end_rec;
    wr_o.rec1 = end_rec;

    // The message is over: start the next one from scratch.
    if (take_o && byte_i.last) begin
      phase_d   = PH_HDR0;
      cnt_d     = '0;
      running_d = '0;
      delta_d   = '0;
      len_d     = '0;
      lnib_d    = '0;
      remain_d  = '0;
      vstart_d  = '0;
      hdr_d     = '0;
      seen_d    = '0;
      err_d     = ST_OK;
      pstart_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      cnt_q     <= '0;
      running_q <= '0;
      delta_q   <= '0;
      len_q     <= '0;
      lnib_q    <= '0;
      remain_q  <= '0;
      vstart_q  <= '0;
      hdr_q     <= '0;
      seen_q    <= '0;
      err_q     <= ST_OK;
      pstart_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      running_q <= running_d;
      delta_q   <= delta_d;
      len_q     <= len_d;
      lnib_q    <= lnib_d;
      remain_q  <= remain_d;
      vstart_q  <= vstart_d;
      hdr_q     <= hdr_d;
      seen_q    <= seen_d;
      err_q     <= err_d;
      pstart_q  <= pstart_d;
    end
  end

endmodule

/* hdl/cmp_rec_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP record queue
// Holds finished records; takes up to two in a cycle and hands out the
// oldest one.
// ----------------------------------------------------------------------------
module cmp_rec_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cmp_pkg::rq_wr_t wr_i,
  output logic            room_o,
  output logic            empty,
  input  logic            pop,
  output cmp_pkg::rec_t   rec_o
);
  import cmp_pkg::*;

  localparam int unsigned AW = $clog2(RQ_DEPTH);

  rec_t            mem_q [RQ_DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [AW:0]     cnt_q, cnt_d;
  logic            rd_en;

  assign empty  = (cnt_q == '0);
  assign room_o = (cnt_q <= (AW+1)'(RQ_DEPTH - 2));
  assign rec_o  = mem_q[rd_q];
  assign rd_en  = pop && !empty;
  assign wr_nxt = wr_q + AW'(1);

  always_comb begin
    wr_d  = wr_q + AW'(wr_i.en0) + AW'(wr_i.en1);
    rd_d  = rd_en ? rd_q + AW'(1) : rd_q;
    cnt_d = cnt_q + (AW+1)'(wr_i.en0) + (AW+1)'(wr_i.en1) - (AW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en0) begin
      mem_q[wr_q] <= wr_i.rec0;
    end
    if (wr_i.en1) begin
      mem_q[wr_nxt] <= wr_i.rec1;
    end
  end

endmodule

/* hdl/coap_message_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message parser
// Decodes a CoAP packet fed one byte per request and returns option records
// and one end-of-message record per packet.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per clock and keeps that rate for as long
// as results are popped. Bytes go through a classifier with a two-entry
// queue, then into the option parser, which updates its state once for each
// byte, and finally into a four-entry record queue. An accepted byte is
// registered in the classifier queue; the parser then registers its records
// in the record queue, from whose head they are popped on the result ports.
// One byte yields at most two records (the last option of a packet followed
// by its end record); the result side hands out one record per cycle, so
// the record queue absorbs the extra record of such a byte.
// The parser only takes a byte while the record queue has room for two
// records, so full rises when results are not popped. The end record is
// always the last record of a packet, and the parser returns to its reset
// state right after it, ready for the next packet. No clearing pass is needed
// after reset. MAX_OPTIONS sets how many options one packet may carry before
// the option error status is given.
// ----------------------------------------------------------------------------
module coap_message_parser #(
  parameter int unsigned MAX_OPTIONS = cmp_pkg::MAX_OPTIONS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        record_kind_o,
  output logic [15:0] option_number_o,
  output logic [15:0] opt_len_o,
  output logic [15:0] data_offset_o,
  output logic [2:0]  status_o,
  output logic [1:0]  version_o,
  output logic [1:0]  msg_type_o,
  output logic [3:0]  token_length_o,
  output logic [7:0]  code_o,
  output logic [15:0] message_id_o,
  output logic [4:0]  option_count_o,
  output logic [15:0] payload_length_o
);
  import cmp_pkg::*;

  // Classified bytes travelling from the front queue to the parser.
  logic   byte_valid;
  logic   byte_take;
  byte_t  cls_byte;

  // Record writes from the parser and the queue's free-space flag.
  rq_wr_t rq_wr;
  logic   rq_room;
  rec_t   head;

  cmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .valid_o     (byte_valid),
    .take_i      (byte_take),
    .byte_o      (cls_byte)
  );

  cmp_back #(
    .MAX_OPTIONS (MAX_OPTIONS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (byte_valid),
    .take_o  (byte_take),
    .byte_i  (cls_byte),
    .room_i  (rq_room),
    .wr_o    (rq_wr)
  );

  cmp_rec_queue u_rec_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (rq_wr),
    .room_o (rq_room),
    .empty  (empty),
    .pop    (pop),
    .rec_o  (head)
  );

  // The oldest record sits on the result ports while empty is low.
  assign record_kind_o    = head.kind;
  assign option_number_o  = head.option_number;
  assign opt_len_o        = head.opt_len;
  assign data_offset_o    = head.data_offset;
  assign status_o         = head.status;
  assign version_o        = head.version;
  assign msg_type_o       = head.msg_type;
  assign token_length_o   = head.token_length;
  assign code_o           = head.code;
  assign message_id_o     = head.message_id;
  assign option_count_o   = head.option_count;
  assign payload_length_o = head.payload_length;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message parser testbench
// Feeds packets byte by byte through the push/full side, keeps a cycle-free
// copy of the parser state to work out every option and end record, and
// checks each popped record field by field against the oldest expectation.
// A short hand-written table comes first, then random packets, mostly well
// formed, with wrapped extensions, cut packets and too many options.
// ----------------------------------------------------------------------------
module tb;
  import cmp_pkg::*;

  typedef enum logic [3:0] {
    P_HDR0, P_HDR1, P_HDR2, P_HDR3, P_TOKEN, P_OPT, P_DX1, P_DXH,
    P_DXL, P_LX1, P_LXH, P_LXL, P_VALUE, P_MARK, P_PAYLOAD, P_IGNORE
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    rec_t       rec;
  } stim_row_t;

  localparam int unsigned RANDOM_BYTES = 1830;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        empty;
  logic        pop;
  logic        record_kind_o;
  logic [15:0] option_number_o;
  logic [15:0] opt_len_o;
  logic [15:0] data_offset_o;
  logic [2:0]  status_o;
  logic [1:0]  version_o;
  logic [1:0]  msg_type_o;
  logic [3:0]  token_length_o;
  logic [7:0]  code_o;
  logic [15:0] message_id_o;
  logic [4:0]  option_count_o;
  logic [15:0] payload_length_o;

  coap_message_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte),
    .last_byte_i      (last_byte),
    .empty            (empty),
    .pop              (pop),
    .record_kind_o    (record_kind_o),
    .option_number_o  (option_number_o),
    .opt_len_o        (opt_len_o),
    .data_offset_o    (data_offset_o),
    .status_o         (status_o),
    .version_o        (version_o),
    .msg_type_o       (msg_type_o),
    .token_length_o   (token_length_o),
    .code_o           (code_o),
    .message_id_o     (message_id_o),
    .option_count_o   (option_count_o),
    .payload_length_o (payload_length_o)
  );

  // Shadow copy of the parser state.
  parse_phase_e pr_phase;
  logic [15:0]  pr_count;
  logic [15:0]  pr_index;
  logic [15:0]  pr_number;
  logic [15:0]  pr_delta;
  logic [15:0]  pr_length;
  logic [3:0]   pr_lnib;
  logic [15:0]  pr_remain;
  logic [15:0]  pr_vstart;
  logic [31:0]  pr_header;
  logic [4:0]   pr_nopt;
  status_e      pr_err;
  logic [15:0]  pr_pstart;

  rec_t        expected_records [$];
  stim_row_t   dir_tab [$];
  logic [7:0]  packet_bytes [$];
  int unsigned mismatches;
  int          burst_left;
  int unsigned bytes_sent;
  int unsigned hold_requests;
  int unsigned holds_served;
  int          hold_cycles;
  int unsigned rx_cycle;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic rec_t make_record(input logic kind, input logic [15:0] num,
                                       input logic [15:0] len, input logic [15:0] off,
                                       input status_e st, input logic [4:0] cnt,
                                       input logic [15:0] plen);
    rec_t r;
    r.kind           = kind;
    r.option_number  = num;
    r.opt_len        = len;
    r.data_offset    = off;
    r.status         = st;
    r.version        = pr_header[31:30];
    r.msg_type       = pr_header[29:28];
    r.token_length   = pr_header[27:24];
    r.code           = pr_header[23:16];
    r.message_id     = pr_header[15:0];
    r.option_count   = cnt;
    r.payload_length = plen;
    return r;
  endfunction

  // End record for the hand-written table: no payload, no option length.
  function automatic rec_t end_rec(input status_e st, input logic [15:0] num,
                                   input logic [4:0] cnt, input logic [31:0] hdr);
    rec_t r;
    r = '0;
    r.kind          = REC_END;
    r.option_number = num;
    r.status        = st;
    r.version       = hdr[31:30];
    r.msg_type      = hdr[29:28];
    r.token_length  = hdr[27:24];
    r.code          = hdr[23:16];
    r.message_id    = hdr[15:0];
    r.option_count  = cnt;
    return r;
  endfunction

  task automatic reset_parser;
    pr_phase  = P_HDR0;
    pr_count  = '0;
    pr_index  = '0;
    pr_number = '0;
    pr_delta  = '0;
    pr_length = '0;
    pr_lnib   = '0;
    pr_remain = '0;
    pr_vstart = '0;
    pr_header = '0;
    pr_nopt   = '0;
    pr_err    = ST_OK;
    pr_pstart = '0;
  endtask

  task automatic fail_packet(input status_e code);
    pr_err   = code;
    pr_phase = P_IGNORE;
  endtask

  task automatic complete_option;
    if (pr_nopt >= MAX_OPTIONS_DEF) begin
      fail_packet(ST_OPT_ERR);
    end else begin
      pr_number = pr_number + pr_delta;
      pr_nopt   = pr_nopt + 5'd1;
      expected_records.push_back(make_record(REC_OPTION, pr_number, pr_length,
                                             pr_vstart, ST_OK, pr_nopt, 16'd0));
      pr_phase = P_OPT;
    end
  endtask

  task automatic finish_header;
    pr_remain = pr_length;
    pr_vstart = sat_inc(pr_index);
    if (pr_remain == 16'd0) complete_option();
    else pr_phase = P_VALUE;
  endtask

  task automatic start_length;
    if (pr_lnib == NIB_EXT1) begin
      pr_phase = P_LX1;
    end else if (pr_lnib == NIB_EXT2) begin
      pr_phase = P_LXH;
    end else begin
      pr_length = {12'd0, pr_lnib};
      finish_header();
    end
  endtask

  // Advances the shadow parser by one accepted byte and queues the records
  // that the byte causes.
  task automatic parse_byte(input logic [7:0] b, input logic l);
    parse_phase_e entry;
    status_e      st;
    logic [15:0]  poff;
    logic [15:0]  plen;
    entry    = pr_phase;
    st       = ST_OK;
    poff     = '0;
    plen     = '0;
    pr_index = pr_count;
    case (pr_phase)
      P_HDR0: begin
        pr_header[31:24] = b;
        pr_phase = P_HDR1;
      end
      P_HDR1: begin
        pr_header[23:16] = b;
        pr_phase = P_HDR2;
      end
      P_HDR2: begin
        pr_header[15:8] = b;
        pr_phase = P_HDR3;
      end
      P_HDR3: begin
        pr_header[7:0] = b;
        if (pr_header[27:24] > MAX_TOKEN) begin
          fail_packet(ST_TOKEN_LONG);
        end else if (pr_header[27:24] == 4'd0) begin
          pr_phase = P_OPT;
        end else begin
          pr_remain = {12'd0, pr_header[27:24]};
          pr_phase  = P_TOKEN;
        end
      end
      P_TOKEN: begin
        pr_remain = pr_remain - 16'd1;
        if (pr_remain == 16'd0) pr_phase = P_OPT;
      end
      P_OPT: begin
        if (b == PAYLOAD_MARKER) begin
          pr_pstart = sat_inc(pr_index);
          pr_phase  = P_MARK;
        end else if (b[7:4] == NIB_STOP) begin
          pr_phase = P_IGNORE;
        end else begin
          pr_lnib = b[3:0];
          if (b[7:4] == NIB_EXT1) begin
            pr_phase = P_DX1;
          end else if (b[7:4] == NIB_EXT2) begin
            pr_phase = P_DXH;
          end else begin
            pr_delta = {12'd0, b[7:4]};
            start_length();
          end
        end
      end
      P_DX1: begin
        pr_delta = {8'd0, b} + EXT1_BIAS;
        start_length();
      end
      P_DXH: begin
        pr_delta = {b, 8'd0};
        pr_phase = P_DXL;
      end
      P_DXL: begin
        pr_delta = (pr_delta | {8'd0, b}) + EXT2_BIAS;
        start_length();
      end
      P_LX1: begin
        pr_length = {8'd0, b} + EXT1_BIAS;
        finish_header();
      end
      P_LXH: begin
        pr_length = {b, 8'd0};
        pr_phase  = P_LXL;
      end
      P_LXL: begin
        pr_length = (pr_length | {8'd0, b}) + EXT2_BIAS;
        finish_header();
      end
      P_VALUE: begin
        pr_remain = pr_remain - 16'd1;
        if (pr_remain == 16'd0) complete_option();
      end
      P_MARK: pr_phase = P_PAYLOAD;
      default: ;
    endcase
    pr_count = sat_inc(pr_count);
    if (l) begin
      if (entry < P_HDR3) begin
        st = ST_SHORT_HDR;
      end else if (pr_phase == P_IGNORE) begin
        st = pr_err;
      end else if (pr_phase == P_TOKEN) begin
        st = ST_TOKEN_CUT;
      end else if (pr_phase >= P_DX1 && pr_phase <= P_VALUE) begin
        st = ST_OPT_ERR;
      end else if (pr_phase == P_PAYLOAD) begin
        poff = pr_pstart;
        plen = pr_count - pr_pstart;
      end
      expected_records.push_back(make_record(REC_END, pr_number, 16'd0, poff, st,
          (st == ST_OK || st == ST_OPT_ERR) ? pr_nopt : 5'd0, plen));
      reset_parser();
    end
  endtask

  // Offers one byte and returns at the edge that accepts it. A new burst
  // may start with an idle gap before the byte goes out.
  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk_i); while (full);
    parse_byte(b, l);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_packet;
    foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
  endtask

  // Stops requesting and waits until every expected record has been popped.
  task automatic drain;
    push <= 1'b0;
    do @(posedge clk_i); while (expected_records.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_record;
    rec_t want;
    if (expected_records.size() == 0) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: record popped with nothing expected, expected none, actual kind %0d",
                 $time, record_kind_o);
    end else begin
      want = expected_records.pop_front();
      compare_field("record_kind", want.kind, record_kind_o);
      compare_field("option_number", want.option_number, option_number_o);
      compare_field("opt_len", want.opt_len, opt_len_o);
      compare_field("data_offset", want.data_offset, data_offset_o);
      compare_field("status", want.status, status_o);
      compare_field("version", want.version, version_o);
      compare_field("msg_type", want.msg_type, msg_type_o);
      compare_field("token_length", want.token_length, token_length_o);
      compare_field("code", want.code, code_o);
      compare_field("message_id", want.message_id, message_id_o);
      compare_field("option_count", want.option_count, option_count_o);
      compare_field("payload_length", want.payload_length, payload_length_o);
    end
  endtask

  // Result side: pops in four rotating patterns, with one long hold-off on
  // request from the stimulus.
  initial begin
    pop <= 1'b0;
    hold_cycles  = 0;
    holds_served = 0;
    rx_cycle = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_record();
      rx_cycle++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_cycles  = 300;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        case ((rx_cycle / 97) % 4)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (rx_cycle % 4) == 0;
          default: pop <= (rx_cycle % 7) < 4;
        endcase
      end
    end
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int         kind;
    int         n_opt;
    int         len;
    int         sel;
    int         cut;
    int unsigned last_drain;
    logic [3:0] tkl;
    logic [3:0] dn;
    logic [3:0] ln;
    logic [7:0] hi;
    logic [7:0] lo;

    rst_ni    <= 1'b0;
    push      <= 1'b0;
    data_byte <= 8'h00;
    last_byte <= 1'b0;
    hold_requests = 0;
    mismatches    = 0;
    burst_left    = 0;
    bytes_sent    = 0;
    reset_parser();

    // Short header: a single byte with every bit set.
    dir_tab.push_back('{8'hFF, 1'b1, 1'b1, end_rec(ST_SHORT_HDR, 16'd0, 5'd0, 32'hFF000000)});
    // Token nibble of nine, the rest of the packet is ignored.
    dir_tab.push_back('{8'h49, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h01, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h7F, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFE, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b1, 1'b1, end_rec(ST_TOKEN_LONG, 16'd0, 5'd0, 32'h49017FFE)});
    // Two-byte token, packet ends after its first byte.
    dir_tab.push_back('{8'h42, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h80, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h80, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h01, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hAB, 1'b1, 1'b1, end_rec(ST_TOKEN_CUT, 16'd0, 5'd0, 32'h42808001)});
    // One-byte and two-byte delta extensions at their maximum, then an
    // option whose value never arrives.
    dir_tab.push_back('{8'h40, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hD1, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h00, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hE0, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'hFF, 1'b0, 1'b0, '0});
    dir_tab.push_back('{8'h31, 1'b1, 1'b1, end_rec(ST_OPT_ERR, 16'd536, 5'd2, 32'h40FFFFFF)});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Typed rows replace the shadow parser's end record, which is always
    // the last one queued for that byte.
    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].data, dir_tab[i].last);
      if (dir_tab[i].typed) expected_records[expected_records.size() - 1] = dir_tab[i].rec;
    end
    drain();

    // The result side holds off for a long stretch while packets keep
    // coming, so the record queue fills and full stalls the requests.
    hold_requests++;
    last_drain = bytes_sent;
    while (bytes_sent < RANDOM_BYTES) begin
      packet_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        // Mostly well-formed packet with random content.
        tkl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
        packet_bytes.push_back({2'($urandom), 2'($urandom), tkl});
        repeat (3) packet_bytes.push_back(8'($urandom));
        if (tkl <= MAX_TOKEN) repeat (tkl) packet_bytes.push_back(8'($urandom));
        n_opt = ($urandom_range(0, 14) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 5);
        repeat (n_opt) begin
          sel = $urandom_range(0, 9);
          dn  = (sel < 7) ? 4'($urandom_range(0, 12)) : ((sel < 9) ? NIB_EXT1 : NIB_EXT2);
          sel = $urandom_range(0, 19);
          hi  = 8'($urandom);
          lo  = 8'($urandom);
          if (sel < 14) begin
            ln  = 4'($urandom_range(0, 12));
            len = ln;
          end else if (sel < 16) begin
            ln  = NIB_STOP;
            len = 15;
          end else if (sel < 18) begin
            ln  = NIB_EXT1;
            lo  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            len = lo + 13;
          end else begin
            // Two-byte length: either wrapped to a small value or just
            // above the two-byte bias.
            ln = NIB_EXT2;
            if ($urandom_range(0, 3) != 0) begin
              hi = 8'hFF;
              lo = 8'($urandom_range(8'hF3, 8'hFF));
            end else begin
              hi = 8'h00;
              lo = 8'($urandom_range(0, 31));
            end
            len = (({hi, lo} + 269) & 16'hFFFF);
          end
          packet_bytes.push_back({dn, ln});
          if (dn == NIB_EXT1) packet_bytes.push_back(8'($urandom));
          if (dn == NIB_EXT2) repeat (2) packet_bytes.push_back(8'($urandom));
          if (ln == NIB_EXT1) packet_bytes.push_back(lo);
          if (ln == NIB_EXT2) begin
            packet_bytes.push_back(hi);
            packet_bytes.push_back(lo);
          end
          repeat (len) packet_bytes.push_back(8'($urandom));
        end
        sel = $urandom_range(0, 3);
        if (sel < 2) begin
          packet_bytes.push_back(PAYLOAD_MARKER);
          repeat ($urandom_range(0, 6)) packet_bytes.push_back(8'($urandom));
        end else if (sel == 3) begin
          packet_bytes.push_back({NIB_STOP, 4'($urandom_range(0, 14))});
          repeat ($urandom_range(0, 3)) packet_bytes.push_back(8'($urandom));
        end
        // Some packets are cut short at a random byte.
        if ($urandom_range(0, 5) == 0) begin
          cut = $urandom_range(1, packet_bytes.size());
          while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
        end
      end else if (kind < 86) begin
        repeat ($urandom_range(1, 12)) packet_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) packet_bytes.push_back(8'($urandom));
      end
      send_packet();
      if (bytes_sent - last_drain > 400) begin
        drain();
        last_drain = bytes_sent;
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
